// ===== rtl/hrt_pkg.sv =====
// Shared types, widths and constants for the history ratio table.
package hrt_pkg;

    // Default table geometry.
    localparam int SIDES_DEF       = 2;
    localparam int PIECE_TYPES_DEF = 6;
    localparam int SQUARES_DEF     = 64;

    // Field and datapath widths.
    localparam int KIND_W   = 3;
    localparam int PIECE_W  = 3;
    localparam int SQUARE_W = 6;
    localparam int DEPTH_W  = 7;
    localparam int WEIGHT_W = 2 * DEPTH_W;
    localparam int PSQ_W    = 16;
    localparam int CNT_W    = 32;
    localparam int SCORE_W  = 31;

    // Score numerator is the cutoff counter scaled up by this shift.
    localparam int SCORE_SHIFT = 5;
    localparam int NUM_W       = CNT_W + SCORE_SHIFT;

    // Load seeding.
    localparam int LOAD_OFFSET = 50;
    localparam int LOAD_MAX    = 1000;
    localparam int LOAD_W      = 10;
    localparam int LOAD_SHIFT  = 9;
    localparam logic [CNT_W-1:0] USE_SEED = CNT_W'(65536);

    localparam logic [SCORE_W-1:0] SCORE_MAX = {SCORE_W{1'b1}};
    localparam logic [CNT_W-1:0]   CNT_MAX   = {CNT_W{1'b1}};

    typedef enum logic [KIND_W-1:0] {
        KIND_LOAD   = 3'd0,
        KIND_CUTOFF = 3'd1,
        KIND_USE    = 3'd2,
        KIND_SCALE  = 3'd3,
        KIND_QUERY  = 3'd4
    } t_kind;

endpackage

// ===== rtl/hrt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module hrt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 768
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/hrt_div.sv =====
// Restoring divider that produces one quotient bit per cycle.
module hrt_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [hrt_pkg::NUM_W-1:0] i_num,
    input  logic [hrt_pkg::CNT_W-1:0] i_den,
    output logic                      o_done,
    output logic [hrt_pkg::NUM_W-1:0] o_quo
);
    import hrt_pkg::*;

    localparam int STEP_W = $clog2(NUM_W + 1);

    logic              r_busy;
    logic              n_busy;
    logic [STEP_W-1:0] r_step;
    logic [STEP_W-1:0] n_step;
    logic              r_done;
    logic              n_done;
    logic [CNT_W-1:0]  r_rem;
    logic [CNT_W-1:0]  n_rem;
    logic [NUM_W-1:0]  r_quo;
    logic [NUM_W-1:0]  n_quo;
    logic [CNT_W-1:0]  r_den;
    logic [CNT_W-1:0]  n_den;

    logic [CNT_W:0]    w_rem_sh;
    logic              w_ge;
    logic [CNT_W:0]    w_diff;

    // The remainder stays below the divisor, so the shifted value fits one extra bit.
    assign w_rem_sh = {r_rem, r_quo[NUM_W-1]};
    assign w_ge     = w_rem_sh >= {1'b0, r_den};
    assign w_diff   = w_rem_sh - {1'b0, r_den};

    always_comb begin
        n_busy = r_busy;
        n_step = r_step;
        n_done = 1'b0;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_den  = r_den;
        if (i_start) begin
            n_busy = 1'b1;
            n_step = STEP_W'(NUM_W);
            n_rem  = '0;
            n_quo  = i_num;
            n_den  = i_den;
        end else if (r_busy) begin
            n_rem  = w_ge ? w_diff[CNT_W-1:0] : w_rem_sh[CNT_W-1:0];
            n_quo  = {r_quo[NUM_W-2:0], w_ge};
            n_step = r_step - STEP_W'(1);
            if (r_step == STEP_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_step <= n_step;
        r_rem  <= n_rem;
        r_quo  <= n_quo;
        r_den  <= n_den;
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

// ===== rtl/history_ratio_table_top.sv =====
// Top level of the history ratio table: sequencer, counter memories and result register.
//
// The block holds a cutoff counter and a use counter for every side, piece and square, in two
// RAMs of SIDES*PIECE_TYPES*SQUARES words. It takes one beat at a time and is not ready while
// it works on it. A load, update or unused kind passes through the read, execute and done states
// before its result beat. A score query also waits in the divide state on the restoring divider,
// which yields one bit of the 37-bit quotient per cycle. A scale-down walks every entry in turn
// (read, then shift and write back) before its result beat. The next beat can be accepted while
// a result still waits.
module history_ratio_table_top #(
    parameter int SIDES       = hrt_pkg::SIDES_DEF,
    parameter int PIECE_TYPES = hrt_pkg::PIECE_TYPES_DEF,
    parameter int SQUARES     = hrt_pkg::SQUARES_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [hrt_pkg::KIND_W-1:0]   i_kind,
    input  logic                         i_side,
    input  logic [hrt_pkg::PIECE_W-1:0]  i_piece,
    input  logic [hrt_pkg::SQUARE_W-1:0] i_square,
    input  logic [hrt_pkg::DEPTH_W-1:0]  i_depth,
    input  logic                         i_quiet,
    input  logic signed [hrt_pkg::PSQ_W-1:0] i_psq_value,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [hrt_pkg::SCORE_W-1:0]  o_score,
    output logic                         o_score_valid
);
    import hrt_pkg::*;

    localparam int DEPTH  = SIDES * PIECE_TYPES * SQUARES;
    localparam int ADDR_W = $clog2(DEPTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_EXEC,
        S_DIV,
        S_DONE
    } t_state;

    t_state              r_state;
    t_state              n_state;
    logic [KIND_W-1:0]   r_kind;
    logic [KIND_W-1:0]   n_kind;
    logic [ADDR_W-1:0]   r_idx;
    logic [ADDR_W-1:0]   n_idx;
    logic                r_in_range;
    logic                n_in_range;
    logic [DEPTH_W-1:0]  r_depth;
    logic [DEPTH_W-1:0]  n_depth;
    logic                r_quiet;
    logic                n_quiet;
    logic signed [PSQ_W-1:0] r_psq;
    logic signed [PSQ_W-1:0] n_psq;
    logic [SCORE_W-1:0]  r_res_score;
    logic [SCORE_W-1:0]  n_res_score;
    logic                r_res_valid;
    logic                n_res_valid;
    logic                r_o_valid;
    logic                n_o_valid;
    logic [SCORE_W-1:0]  r_score;
    logic [SCORE_W-1:0]  n_score;
    logic                r_score_valid;
    logic                n_score_valid;

    logic [ADDR_W:0]     w_row;
    logic [ADDR_W:0]     w_idx_full;
    logic                w_in_range;
    logic [CNT_W-1:0]    w_rd_cut;
    logic [CNT_W-1:0]    w_rd_use;
    logic                w_cut_we;
    logic                w_use_we;
    logic [CNT_W-1:0]    w_cut_wdata;
    logic [CNT_W-1:0]    w_use_wdata;
    logic [WEIGHT_W-1:0] w_weight;
    logic [CNT_W:0]      w_cut_sum;
    logic [CNT_W:0]      w_use_sum;
    logic [CNT_W-1:0]    w_cut_sat;
    logic [CNT_W-1:0]    w_use_sat;
    logic signed [PSQ_W:0] w_psq_sum;
    logic [LOAD_W-1:0]   w_load;
    logic [CNT_W-1:0]    w_load_cut;
    logic [2:0]          w_shift;
    logic                w_exec;
    logic                w_last;
    logic                w_div_start;
    logic                w_div_done;
    logic [NUM_W-1:0]    w_quo;

    // Table index from side, piece and square; out-of-range loads and updates never write memory.
    assign w_row      = (ADDR_W+1)'(i_side) * (ADDR_W+1)'(PIECE_TYPES) + (ADDR_W+1)'(i_piece);
    assign w_idx_full = w_row * (ADDR_W+1)'(SQUARES) + (ADDR_W+1)'(i_square);
    assign w_in_range = (i_side < SIDES) && (i_piece < PIECE_TYPES) && (i_square < SQUARES);

    assign w_exec = (r_state == S_EXEC);
    assign w_last = (r_idx == ADDR_W'(DEPTH - 1));

    // Saturating adds of depth squared.
    assign w_weight  = WEIGHT_W'(r_depth) * WEIGHT_W'(r_depth);
    assign w_cut_sum = {1'b0, w_rd_cut} + (CNT_W+1)'(w_weight);
    assign w_use_sum = {1'b0, w_rd_use} + (CNT_W+1)'(w_weight);
    assign w_cut_sat = w_cut_sum[CNT_W] ? CNT_MAX : w_cut_sum[CNT_W-1:0];
    assign w_use_sat = w_use_sum[CNT_W] ? CNT_MAX : w_use_sum[CNT_W-1:0];

    // Load value: psq plus offset, clamped, then scaled.
    assign w_psq_sum = (PSQ_W+1)'(r_psq) + (PSQ_W+1)'(LOAD_OFFSET);
    always_comb begin
        priority if (w_psq_sum < 0) begin
            w_load = '0;
        end else if (w_psq_sum > (PSQ_W+1)'(LOAD_MAX)) begin
            w_load = LOAD_W'(LOAD_MAX);
        end else begin
            w_load = w_psq_sum[LOAD_W-1:0];
        end
    end
    assign w_load_cut = CNT_W'({w_load, LOAD_SHIFT'(0)});

    // The shift is 22 minus the leading zero count, clamped to 0..4, which depends only on
    // whether the top set bit sits at position 13 or above, or exactly at 12, 11 or 10.
    always_comb begin
        priority if (w_rd_use[CNT_W-1:13] != '0) begin
            w_shift = 3'd4;
        end else if (w_rd_use[12]) begin
            w_shift = 3'd3;
        end else if (w_rd_use[11]) begin
            w_shift = 3'd2;
        end else if (w_rd_use[10]) begin
            w_shift = 3'd1;
        end else begin
            w_shift = 3'd0;
        end
    end

    always_comb begin
        w_cut_we    = 1'b0;
        w_use_we    = 1'b0;
        w_cut_wdata = w_rd_cut;
        w_use_wdata = w_rd_use;
        unique case (r_kind)
            KIND_LOAD: begin
                w_cut_we    = w_exec && r_in_range;
                w_use_we    = w_exec && r_in_range;
                w_cut_wdata = w_load_cut;
                w_use_wdata = USE_SEED;
            end
            KIND_CUTOFF: begin
                w_cut_we    = w_exec && r_in_range && r_quiet;
                w_cut_wdata = w_cut_sat;
            end
            KIND_USE: begin
                w_use_we    = w_exec && r_in_range && r_quiet;
                w_use_wdata = w_use_sat;
            end
            KIND_SCALE: begin
                w_cut_we    = w_exec;
                w_use_we    = w_exec;
                w_cut_wdata = w_rd_cut >> w_shift;
                w_use_wdata = w_rd_use >> w_shift;
            end
            default: begin
            end
        endcase
    end

    assign w_div_start = w_exec && (r_kind == KIND_QUERY) && r_in_range && (w_rd_use != '0);

    hrt_ram #(
        .WIDTH (CNT_W),
        .DEPTH (DEPTH)
    ) u_cut_ram (
        .i_clk   (i_clk),
        .i_we    (w_cut_we),
        .i_waddr (r_idx),
        .i_wdata (w_cut_wdata),
        .i_raddr (r_idx),
        .o_rdata (w_rd_cut)
    );

    hrt_ram #(
        .WIDTH (CNT_W),
        .DEPTH (DEPTH)
    ) u_use_ram (
        .i_clk   (i_clk),
        .i_we    (w_use_we),
        .i_waddr (r_idx),
        .i_wdata (w_use_wdata),
        .i_raddr (r_idx),
        .o_rdata (w_rd_use)
    );

    hrt_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   ({w_rd_cut, SCORE_SHIFT'(0)}),
        .i_den   (w_rd_use),
        .o_done  (w_div_done),
        .o_quo   (w_quo)
    );

    always_comb begin
        n_state       = r_state;
        n_kind        = r_kind;
        n_idx         = r_idx;
        n_in_range    = r_in_range;
        n_depth       = r_depth;
        n_quiet       = r_quiet;
        n_psq         = r_psq;
        n_res_score   = r_res_score;
        n_res_valid   = r_res_valid;
        n_o_valid     = r_o_valid;
        n_score       = r_score;
        n_score_valid = r_score_valid;

        if (r_o_valid && i_ready) begin
            n_o_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_kind     = i_kind;
                    n_in_range = w_in_range;
                    n_depth    = i_depth;
                    n_quiet    = i_quiet;
                    n_psq      = i_psq_value;
                    n_idx      = (i_kind == KIND_SCALE || !w_in_range) ?
                                 '0 : w_idx_full[ADDR_W-1:0];
                    n_state    = S_READ;
                end
            end
            S_READ: begin
                n_state = S_EXEC;
            end
            S_EXEC: begin
                n_res_score = '0;
                n_res_valid = 1'b0;
                n_state     = S_DONE;
                unique case (r_kind)
                    KIND_SCALE: begin
                        if (!w_last) begin
                            n_idx   = r_idx + ADDR_W'(1);
                            n_state = S_READ;
                        end
                    end
                    KIND_QUERY: begin
                        n_res_valid = 1'b1;
                        if (w_div_start) begin
                            n_state = S_DIV;
                        end else if (r_in_range) begin
                            // An empty use counter answers the saturated maximum.
                            n_res_score = SCORE_MAX;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_DIV: begin
                if (w_div_done) begin
                    n_res_score = (w_quo > NUM_W'(SCORE_MAX)) ? SCORE_MAX : w_quo[SCORE_W-1:0];
                    n_state     = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_o_valid || i_ready) begin
                    n_o_valid     = 1'b1;
                    n_score       = r_res_score;
                    n_score_valid = r_res_valid;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_o_valid <= n_o_valid;
        end
        r_kind        <= n_kind;
        r_idx         <= n_idx;
        r_in_range    <= n_in_range;
        r_depth       <= n_depth;
        r_quiet       <= n_quiet;
        r_psq         <= n_psq;
        r_res_score   <= n_res_score;
        r_res_valid   <= n_res_valid;
        r_score       <= n_score;
        r_score_valid <= n_score_valid;
    end

    assign o_ready       = (r_state == S_IDLE);
    assign o_valid       = r_o_valid;
    assign o_score       = r_score;
    assign o_score_valid = r_score_valid;

`ifndef SYNTHESIS
    a_accept_reads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> (r_state == S_READ))
        else $error("accepted beat did not start a table read");

    a_write_in_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cut_we || w_use_we) |-> (r_state == S_EXEC))
        else $error("table write outside the execute step");

    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == S_DIV))
        else $error("divider finished while no query was waiting");

    a_div_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_start |=> (r_state == S_DIV))
        else $error("divider started without the sequencer waiting on it");

    a_score_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_score_valid) |-> (o_score == '0))
        else $error("non-query beat carries a nonzero score");
`endif

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for the history ratio table: directed, fill and random beats.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import hrt_pkg::*;

    localparam int ENTRIES     = SIDES_DEF * PIECE_TYPES_DEF * SQUARES_DEF;
    localparam int HOLD_CYCLES = 400;
    localparam int PHASE_BEATS = 30;
    localparam int HOT_COUNT   = 8;
    localparam logic [KIND_W-1:0] KIND_SPARE = 3'd5;

    typedef struct {
        logic [KIND_W-1:0]       kind;
        logic                    side;
        logic [PIECE_W-1:0]      piece;
        logic [SQUARE_W-1:0]     square;
        logic [DEPTH_W-1:0]      depth;
        logic                    quiet;
        logic signed [PSQ_W-1:0] psq;
    } move_t;

    typedef struct {
        logic [SCORE_W-1:0] score;
        logic               score_valid;
    } answer_t;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_valid = 1'b0;
    logic                    o_ready;
    logic [KIND_W-1:0]       i_kind = '0;
    logic                    i_side = 1'b0;
    logic [PIECE_W-1:0]      i_piece = '0;
    logic [SQUARE_W-1:0]     i_square = '0;
    logic [DEPTH_W-1:0]      i_depth = '0;
    logic                    i_quiet = 1'b0;
    logic signed [PSQ_W-1:0] i_psq_value = '0;
    logic                    o_valid;
    logic                    i_ready = 1'b0;
    logic [SCORE_W-1:0]      o_score;
    logic                    o_score_valid;

    // Mirror of the two counter memories.
    logic [CNT_W-1:0] cutoff_mirror [ENTRIES];
    logic [CNT_W-1:0] use_mirror [ENTRIES];

    move_t   pending_moves [$];
    answer_t expected_scores [$];
    move_t   offered_move;
    move_t   hot_spots [HOT_COUNT];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int bad_results = 0;
    int hold_left = 0;
    logic hold_req = 1'b0;
    logic hold_ack = 1'b0;

    history_ratio_table_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_kind        (i_kind),
        .i_side        (i_side),
        .i_piece       (i_piece),
        .i_square      (i_square),
        .i_depth       (i_depth),
        .i_quiet       (i_quiet),
        .i_psq_value   (i_psq_value),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_score       (o_score),
        .o_score_valid (o_score_valid)
    );

    always #2 i_clk = ~i_clk;

    function automatic int leading_zeros(logic [CNT_W-1:0] v);
        for (int b = CNT_W - 1; b >= 0; b--) begin
            if (v[b]) begin
                return CNT_W - 1 - b;
            end
        end
        return CNT_W;
    endfunction

    function automatic logic [CNT_W-1:0] add_capped(logic [CNT_W-1:0] a,
                                                    logic [WEIGHT_W-1:0] w);
        logic [CNT_W:0] sum;
        sum = (CNT_W + 1)'(a) + (CNT_W + 1)'(w);
        return sum[CNT_W] ? CNT_MAX : sum[CNT_W-1:0];
    endfunction

    // Applies one accepted beat to the mirror and returns the result it must produce.
    function automatic answer_t apply_move(move_t m);
        answer_t           ans;
        logic              in_range;
        int                idx;
        int                seed;
        int                sh;
        logic [WEIGHT_W-1:0] weight;
        logic [NUM_W-1:0]  num;
        logic [NUM_W-1:0]  quot;
        ans.score = '0;
        ans.score_valid = 1'b0;
        in_range = m.piece < PIECE_TYPES_DEF;
        idx = (int'(m.side) * PIECE_TYPES_DEF + int'(m.piece)) * SQUARES_DEF
              + int'(m.square);
        weight = WEIGHT_W'(m.depth) * WEIGHT_W'(m.depth);
        case (m.kind)
            KIND_LOAD: begin
                if (in_range) begin
                    seed = int'(m.psq) + LOAD_OFFSET;
                    if (seed < 0) seed = 0;
                    if (seed > LOAD_MAX) seed = LOAD_MAX;
                    cutoff_mirror[idx] = CNT_W'(seed) << LOAD_SHIFT;
                    use_mirror[idx] = USE_SEED;
                end
            end
            KIND_CUTOFF: begin
                if (in_range && m.quiet) cutoff_mirror[idx] = add_capped(cutoff_mirror[idx], weight);
            end
            KIND_USE: begin
                if (in_range && m.quiet) use_mirror[idx] = add_capped(use_mirror[idx], weight);
            end
            KIND_SCALE: begin
                for (int i = 0; i < ENTRIES; i++) begin
                    sh = 22 - leading_zeros(use_mirror[i]);
                    if (sh < 0) sh = 0;
                    if (sh > 4) sh = 4;
                    use_mirror[i] = use_mirror[i] >> sh;
                    cutoff_mirror[i] = cutoff_mirror[i] >> sh;
                end
            end
            KIND_QUERY: begin
                ans.score_valid = 1'b1;
                if (in_range) begin
                    if (use_mirror[idx] == '0) begin
                        ans.score = SCORE_MAX;
                    end else begin
                        num = NUM_W'(cutoff_mirror[idx]) << SCORE_SHIFT;
                        quot = num / NUM_W'(use_mirror[idx]);
                        ans.score = (quot > NUM_W'(SCORE_MAX)) ? SCORE_MAX : quot[SCORE_W-1:0];
                    end
                end
            end
            default: begin
            end
        endcase
        return ans;
    endfunction

    task automatic add_move(logic [KIND_W-1:0] kind, logic side, logic [PIECE_W-1:0] piece,
                            logic [SQUARE_W-1:0] square, logic [DEPTH_W-1:0] depth,
                            logic quiet, logic signed [PSQ_W-1:0] psq);
        move_t m;
        m.kind = kind;
        m.side = side;
        m.piece = piece;
        m.square = square;
        m.depth = depth;
        m.quiet = quiet;
        m.psq = psq;
        pending_moves = {pending_moves, m};
    endtask

    // Random beat; only used once every entry has been loaded, so any entry may be read.
    function automatic move_t random_move();
        move_t m;
        int    r;
        r = $urandom_range(99);
        if (r < 10) m.kind = KIND_LOAD;
        else if (r < 40) m.kind = KIND_CUTOFF;
        else if (r < 65) m.kind = KIND_USE;
        else if (r < 67) m.kind = KIND_SCALE;
        else if (r < 96) m.kind = KIND_QUERY;
        else m.kind = KIND_SPARE + KIND_W'($urandom_range(2));
        if ($urandom_range(3) != 0) begin
            m = '{kind: m.kind, side: hot_spots[$urandom_range(HOT_COUNT - 1)].side,
                  piece: '0, square: '0, depth: '0, quiet: 1'b0, psq: '0};
            r = $urandom_range(HOT_COUNT - 1);
            m.side = hot_spots[r].side;
            m.piece = hot_spots[r].piece;
            m.square = hot_spots[r].square;
        end else begin
            m.side = 1'($urandom_range(1));
            m.piece = PIECE_W'($urandom_range(PIECE_TYPES_DEF - 1));
            m.square = SQUARE_W'($urandom_range(SQUARES_DEF - 1));
        end
        if ($urandom_range(19) == 0) m.piece = PIECE_W'($urandom_range(7, PIECE_TYPES_DEF));
        m.depth = DEPTH_W'($urandom_range(127));
        m.quiet = $urandom_range(9) != 0;
        if ($urandom_range(1) == 0) m.psq = PSQ_W'($urandom);
        else m.psq = PSQ_W'(int'($urandom_range(1100)) - 100);
        return m;
    endfunction

    // Sender: a beat stays on the port until it is taken.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) expected_scores = {expected_scores, apply_move(offered_move)};
            if (!i_valid || o_ready) begin
                if (pending_moves.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    offered_move = pending_moves.pop_front();
                    i_kind <= offered_move.kind;
                    i_side <= offered_move.side;
                    i_piece <= offered_move.piece;
                    i_square <= offered_move.square;
                    i_depth <= offered_move.depth;
                    i_quiet <= offered_move.quiet;
                    i_psq_value <= offered_move.psq;
                    i_valid <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Long back-pressure window, started by toggling hold_req.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (hold_req != hold_ack) begin
            hold_left <= HOLD_CYCLES;
            hold_ack <= hold_req;
        end
    end

    // Receiver and checker.
    always @(posedge i_clk) begin
        answer_t want;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (expected_scores.size() == 0) begin
                    bad_results++;
                    if (bad_results <= 10) begin
                        $display("%0t: unexpected result beat score=%0d valid=%0b",
                                 $realtime, o_score, o_score_valid);
                    end
                end else begin
                    want = expected_scores.pop_front();
                    if (o_score !== want.score || o_score_valid !== want.score_valid) begin
                        bad_results++;
                        if (bad_results <= 10) begin
                            $display("%0t: bad result: score %0d (want %0d) valid %0b (want %0b)",
                                     $realtime, o_score, want.score, o_score_valid,
                                     want.score_valid);
                        end
                    end
                end
            end
            i_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic wait_drained();
        while (pending_moves.size() != 0 || i_valid || expected_scores.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    initial begin
        int send_pct [4];
        int recv_pct [4];
        send_pct = '{0, 56, 0, 26};
        recv_pct = '{0, 0, 56, 26};
        i_rst_n = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: clamp bounds, quiet and non-quiet updates, zero depth, bad pieces,
        // spare kinds. Only entries loaded here are read before the full fill.
        add_move(KIND_LOAD, 1'b0, 3'd0, 6'd0, 7'd127, 1'b1, 16'sh8000);
        add_move(KIND_QUERY, 1'b0, 3'd0, 6'd0, 7'd0, 1'b0, 16'sh0000);
        add_move(KIND_LOAD, 1'b1, 3'd5, 6'd63, 7'd0, 1'b0, 16'sh7FFF);
        add_move(KIND_QUERY, 1'b1, 3'd5, 6'd63, 7'd127, 1'b1, 16'shFFFF);
        add_move(KIND_LOAD, 1'b0, 3'd2, 6'd10, 7'd5, 1'b1, 16'sd0);
        add_move(KIND_LOAD, 1'b0, 3'd3, 6'd11, 7'd5, 1'b1, -16'sd50);
        add_move(KIND_QUERY, 1'b0, 3'd3, 6'd11, 7'd5, 1'b1, 16'sd0);
        add_move(KIND_LOAD, 1'b0, 3'd3, 6'd11, 7'd5, 1'b1, 16'sd950);
        add_move(KIND_LOAD, 1'b1, 3'd4, 6'd40, 7'd5, 1'b1, 16'sd951);
        add_move(KIND_CUTOFF, 1'b1, 3'd5, 6'd63, 7'd127, 1'b1, 16'sd0);
        add_move(KIND_CUTOFF, 1'b1, 3'd5, 6'd63, 7'd127, 1'b0, 16'sd0);
        add_move(KIND_USE, 1'b1, 3'd5, 6'd63, 7'd127, 1'b1, 16'sd0);
        add_move(KIND_USE, 1'b1, 3'd5, 6'd63, 7'd100, 1'b0, 16'sd0);
        add_move(KIND_USE, 1'b0, 3'd2, 6'd10, 7'd0, 1'b1, 16'sd0);
        add_move(KIND_QUERY, 1'b1, 3'd5, 6'd63, 7'd0, 1'b0, 16'sd0);
        add_move(KIND_QUERY, 1'b0, 3'd2, 6'd10, 7'd0, 1'b0, 16'sd0);
        add_move(KIND_LOAD, 1'b0, 3'd6, 6'd1, 7'd0, 1'b1, 16'sd100);
        add_move(KIND_CUTOFF, 1'b1, 3'd7, 6'd2, 7'd9, 1'b1, 16'sd0);
        add_move(KIND_QUERY, 1'b1, 3'd7, 6'd63, 7'd0, 1'b1, 16'sd0);
        add_move(KIND_SPARE, 1'b1, 3'd5, 6'd63, 7'd127, 1'b1, 16'sh7FFF);
        add_move(KIND_SPARE + 3'd1, 1'b0, 3'd0, 6'd0, 7'd0, 1'b0, 16'sh8000);
        add_move({KIND_W{1'b1}}, 1'b1, 3'd2, 6'd10, 7'd3, 1'b1, 16'sd1);
        wait_drained();

        // Every entry must hold a value before a scale-down reads the whole table.
        for (int s = 0; s < SIDES_DEF; s++) begin
            for (int p = 0; p < PIECE_TYPES_DEF; p++) begin
                for (int q = 0; q < SQUARES_DEF; q++) begin
                    add_move(KIND_LOAD, s[0], PIECE_W'(p), SQUARE_W'(q), DEPTH_W'($urandom),
                             1'($urandom_range(1)), PSQ_W'(int'($urandom_range(1200)) - 150));
                end
            end
        end
        add_move(KIND_SCALE, 1'b0, 3'd0, 6'd0, 7'd0, 1'b0, 16'sd0);
        add_move(KIND_QUERY, 1'b1, 3'd5, 6'd63, 7'd0, 1'b0, 16'sd0);
        add_move(KIND_SCALE, 1'b1, 3'd7, 6'd63, 7'd127, 1'b1, 16'shFFFF);
        add_move(KIND_QUERY, 1'b0, 3'd0, 6'd0, 7'd0, 1'b0, 16'sd0);
        wait_drained();

        for (int h = 0; h < HOT_COUNT; h++) begin
            hot_spots[h].side = 1'($urandom_range(1));
            hot_spots[h].piece = PIECE_W'($urandom_range(PIECE_TYPES_DEF - 1));
            hot_spots[h].square = SQUARE_W'($urandom_range(SQUARES_DEF - 1));
        end

        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = send_pct[ph];
            recv_stall_pct = recv_pct[ph];
            // The receiver blocks for a while as the sender keeps offering beats.
            if (ph == 0) hold_req = ~hold_req;
            repeat (PHASE_BEATS) pending_moves = {pending_moves, random_move()};
            wait_drained();
        end

        repeat (60) @(negedge i_clk);
        if (bad_results == 0 && expected_scores.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #8ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
